// ----- src/i2cebm_pkg.sv -----
// Shared types and codes for the I2C EEPROM byte master.
`default_nettype none
package i2cebm_pkg;

  localparam int ActW = 2;

  localparam logic [ActW-1:0] ACT_TICK  = 2'd0;
  localparam logic [ActW-1:0] ACT_WRITE = 2'd1;
  localparam logic [ActW-1:0] ACT_READ  = 2'd2;

  localparam logic [7:0] DEV_RESET = 8'd160;

  // classified command word handed from the front end to the sequencer
  typedef struct packed {
    logic       tick;
    logic       start;
    logic       rd;
    logic [7:0] word_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } cmd_t;

  // result word, lowest bit is scl_out
  typedef struct packed {
    logic [2:0] pad;
    logic [7:0] read_data;
    logic       ack_ok;
    logic       done;
    logic       busy;
    logic       sda;
    logic       scl;
  } res_t;

endpackage
`default_nettype wire

// ----- src/i2cebm_front.sv -----
// Input side: takes stream words and classifies the action code.
`default_nettype none
module i2cebm_front (
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,  // word_addr, write_data, sda_in
  input  wire logic [i2cebm_pkg::ActW-1:0] s_tuser,  // action
  output logic                             push,
  output i2cebm_pkg::cmd_t                 cmd,
  input  wire logic                        q_full
);

  assign s_tready = !q_full;
  assign push     = s_tvalid && !q_full;

  always_comb begin
    cmd.tick       = (s_tuser == i2cebm_pkg::ACT_TICK);
    cmd.start      = (s_tuser == i2cebm_pkg::ACT_WRITE) || (s_tuser == i2cebm_pkg::ACT_READ);
    cmd.rd         = (s_tuser == i2cebm_pkg::ACT_READ);
    cmd.word_addr  = s_tdata[7:0];
    cmd.write_data = s_tdata[15:8];
    cmd.sda_in     = s_tdata[16];
  end

endmodule
`default_nettype wire

// ----- src/i2cebm_queue.sv -----
// Two-entry command queue between front end and sequencer.
`default_nettype none
module i2cebm_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire i2cebm_pkg::cmd_t push_cmd,
  output logic                  full,
  output logic                  not_empty,
  input  wire logic             pop,
  output i2cebm_pkg::cmd_t      head
);

  i2cebm_pkg::cmd_t mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/i2cebm_back.sv -----
// Bus sequencer: runs one quarter bit phase per tick word and registers the result.
`default_nettype none
module i2cebm_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       dev_byte,
  input  wire logic             q_valid,
  input  wire i2cebm_pkg::cmd_t head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic [15:0]           m_tdata
);

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_START  = 5'd1;
  localparam logic [4:0] PH_DEVW   = 5'd2;
  localparam logic [4:0] PH_DEVW_A = 5'd3;
  localparam logic [4:0] PH_WA     = 5'd4;
  localparam logic [4:0] PH_WA_A   = 5'd5;
  localparam logic [4:0] PH_DATA   = 5'd6;
  localparam logic [4:0] PH_DATA_A = 5'd7;
  localparam logic [4:0] PH_RSTART = 5'd8;
  localparam logic [4:0] PH_DEVR   = 5'd9;
  localparam logic [4:0] PH_DEVR_A = 5'd10;
  localparam logic [4:0] PH_READ   = 5'd11;
  localparam logic [4:0] PH_NACK   = 5'd12;
  localparam logic [4:0] PH_STOP   = 5'd13;

  logic [4:0] phase, phase_next;
  logic [1:0] qstep, qstep_next;
  logic [3:0] bcnt, bcnt_next;
  logic [7:0] shift, shift_next;
  logic [7:0] waddr, waddr_next;
  logic [7:0] wdata, wdata_next;
  logic       rd, rd_next;
  logic [7:0] rx, rx_next;
  logic       ack, ack_next;
  logic       scl, scl_next;
  logic       sda, sda_next;
  logic       fin;
  logic [3:0] bcnt_inc;
  i2cebm_pkg::res_t res;

  assign pop      = q_valid && (!m_tvalid || m_tready);
  assign bcnt_inc = bcnt + 4'd1;

  always_comb begin
    phase_next = phase;
    qstep_next = qstep;
    bcnt_next  = bcnt;
    shift_next = shift;
    waddr_next = waddr;
    wdata_next = wdata;
    rd_next    = rd;
    rx_next    = rx;
    ack_next   = ack;
    scl_next   = scl;
    sda_next   = sda;
    fin        = 1'b0;
    if (head.tick && phase != PH_IDLE) begin
      qstep_next = qstep + 2'd1;
      case (phase)
        PH_START, PH_RSTART: begin
          case (qstep)
            2'd0: sda_next = 1'b1;
            2'd1: scl_next = 1'b1;
            2'd2: sda_next = 1'b0;
            default: begin
              scl_next  = 1'b0;
              bcnt_next = 4'd0;
              if (phase == PH_START) begin
                phase_next = PH_DEVW;
                shift_next = dev_byte;
              end else begin
                phase_next = PH_DEVR;
                shift_next = dev_byte + 8'd1;
              end
            end
          endcase
        end
        PH_DEVW, PH_WA, PH_DATA, PH_DEVR: begin
          case (qstep)
            2'd0: begin
              scl_next = 1'b0;
              sda_next = shift[7];
            end
            2'd1: scl_next = 1'b1;
            2'd2: ;
            default: begin
              scl_next   = 1'b0;
              shift_next = {shift[6:0], 1'b0};
              bcnt_next  = bcnt_inc;
              if (bcnt_inc[3]) begin
                bcnt_next  = 4'd0;
                phase_next = phase + 5'd1;
              end
            end
          endcase
        end
        PH_DEVW_A, PH_WA_A, PH_DATA_A, PH_DEVR_A: begin
          case (qstep)
            2'd0: begin
              scl_next = 1'b0;
              sda_next = 1'b1;
            end
            2'd1: scl_next = 1'b1;
            2'd2: begin
              if (head.sda_in) begin
                ack_next = 1'b0;
              end
            end
            default: begin
              scl_next = 1'b0;
              if (!ack) begin
                phase_next = PH_STOP;
              end else if (phase == PH_DEVW_A) begin
                phase_next = PH_WA;
                shift_next = waddr;
                bcnt_next  = 4'd0;
              end else if (phase == PH_WA_A) begin
                if (rd) begin
                  phase_next = PH_RSTART;
                end else begin
                  phase_next = PH_DATA;
                  shift_next = wdata;
                  bcnt_next  = 4'd0;
                end
              end else if (phase == PH_DATA_A) begin
                phase_next = PH_STOP;
              end else begin
                phase_next = PH_READ;
                bcnt_next  = 4'd0;
              end
            end
          endcase
        end
        PH_READ: begin
          case (qstep)
            2'd0: begin
              scl_next = 1'b0;
              sda_next = 1'b1;
            end
            2'd1: scl_next = 1'b1;
            2'd2: rx_next = {rx[6:0], head.sda_in};
            default: begin
              scl_next  = 1'b0;
              bcnt_next = bcnt_inc;
              if (bcnt_inc[3]) begin
                bcnt_next  = 4'd0;
                phase_next = PH_NACK;
              end
            end
          endcase
        end
        PH_NACK: begin
          case (qstep)
            2'd0: begin
              scl_next = 1'b0;
              sda_next = 1'b1;
            end
            2'd1: scl_next = 1'b1;
            2'd2: ;
            default: begin
              scl_next   = 1'b0;
              phase_next = PH_STOP;
            end
          endcase
        end
        PH_STOP: begin
          case (qstep)
            2'd0: begin
              scl_next = 1'b0;
              sda_next = 1'b0;
            end
            2'd1: scl_next = 1'b1;
            2'd2: sda_next = 1'b1;
            default: begin
              scl_next   = 1'b1;
              sda_next   = 1'b1;
              phase_next = PH_IDLE;
              fin        = 1'b1;
            end
          endcase
        end
        default: begin
          phase_next = PH_IDLE;
          qstep_next = 2'd0;
          bcnt_next  = 4'd0;
          scl_next   = 1'b1;
          sda_next   = 1'b1;
        end
      endcase
    end else if (head.start && phase == PH_IDLE) begin
      waddr_next = head.word_addr;
      wdata_next = head.write_data;
      rd_next    = head.rd;
      rx_next    = 8'd0;
      ack_next   = 1'b1;
      bcnt_next  = 4'd0;
      qstep_next = 2'd0;
      shift_next = 8'd0;
      phase_next = PH_START;
    end
  end

  always_comb begin
    res.pad       = 3'd0;
    res.scl       = scl_next;
    res.sda       = sda_next;
    res.busy      = (phase_next != PH_IDLE);
    res.done      = fin;
    res.ack_ok    = fin && ack_next;
    res.read_data = (fin && ack_next && rd_next) ? rx_next : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      qstep    <= 2'd0;
      bcnt     <= 4'd0;
      shift    <= 8'd0;
      waddr    <= 8'd0;
      wdata    <= 8'd0;
      rd       <= 1'b0;
      rx       <= 8'd0;
      ack      <= 1'b1;
      scl      <= 1'b1;
      sda      <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      if (pop) begin
        phase    <= phase_next;
        qstep    <= qstep_next;
        bcnt     <= bcnt_next;
        shift    <= shift_next;
        waddr    <= waddr_next;
        wdata    <= wdata_next;
        rd       <= rd_next;
        rx       <= rx_next;
        ack      <= ack_next;
        scl      <= scl_next;
        sda      <= sda_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= res;
    end
  end

endmodule
`default_nettype wire

// ----- src/i2c_eeprom_byte_master_core.sv -----
// Top level of the I2C EEPROM byte master: front end, command queue, sequencer, register.
//
// One input word is one step: action 0 advances the I2C bus by a quarter bit,
// action 1 starts a byte write, action 2 starts a random read, action 3 does
// nothing. Every input word gives exactly one output word carrying the bus line
// levels, busy, done, ack_ok and read data. The block takes one word per clock
// cycle while the queue is not full; an accepted word passes through a two-entry
// queue in front of the sequencer into the output register. The sequencer handles
// one queued word per cycle whenever its output register is free or being drained.
// The device address byte (write bit clear, reset 0xA0) sits at APB addresses 0
// to 3, as only paddr[2] is decoded; the read address uses that value plus one.
`default_nettype none
module i2c_eeprom_byte_master_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [23:0]                 s_tdata,  // [7:0] word_addr, [15:8] write_data, [16] sda_in
  input  wire logic [i2cebm_pkg::ActW-1:0] s_tuser,  // [1:0] action
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [15:0]                      m_tdata,  // [0] scl_out, [1] sda_out, [2] busy_res,
                                                     // [3] done_res, [4] ack_ok, [12:5] read_data
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  logic             push;
  logic             q_full;
  logic             q_valid;
  logic             pop;
  i2cebm_pkg::cmd_t in_cmd;
  i2cebm_pkg::cmd_t head;
  logic [7:0]       dev_byte;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {24'd0, dev_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_byte <= i2cebm_pkg::DEV_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      dev_byte <= pwdata[7:0];
    end
  end

  i2cebm_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .cmd      (in_cmd),
    .q_full   (q_full)
  );

  i2cebm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (in_cmd),
    .full      (q_full),
    .not_empty (q_valid),
    .pop       (pop),
    .head      (head)
  );

  i2cebm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .dev_byte (dev_byte),
    .q_valid  (q_valid),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- src/i2cebm_checker.sv -----
// Port-level checks for the I2C EEPROM byte master, bound to the top level.
`default_nettype none
module i2cebm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // a held output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // input side only backs up after the output side has stalled
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && $past(m_tvalid && !m_tready))
    else $error("input stalled without output stall");

  // read data only shows on a successful finish
  a_read_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[12:5] != 8'd0) |-> m_tdata[3] && m_tdata[4] && !m_tdata[2])
    else $error("read data outside a successful finish");

endmodule

bind i2c_eeprom_byte_master_core i2cebm_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

// ----- bench/i2c_eeprom_byte_master_core_tb.sv -----
// Self-checking bench for the I2C EEPROM byte master core: directed and random transactions.
module i2c_eeprom_byte_master_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [i2cebm_pkg::ActW-1:0] ACT_NOP = 2'd3;
  localparam logic [2:0]                  REG_DEV = 3'd0;

  typedef enum logic [4:0] {
    BP_IDLE, BP_START, BP_DEVW, BP_DEVW_A, BP_WA, BP_WA_A, BP_DATA, BP_DATA_A,
    BP_RSTART, BP_DEVR, BP_DEVR_A, BP_READ, BP_NACK, BP_STOP
  } bus_phase_t;

  logic                        clk;
  logic                        rst;
  logic                        s_tvalid;
  logic                        s_tready;
  logic [23:0]                 s_tdata;
  logic [i2cebm_pkg::ActW-1:0] s_tuser;
  logic                        m_tvalid;
  logic                        m_tready;
  logic [15:0]                 m_tdata;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [2:0]                  paddr;
  logic [31:0]                 pwdata;
  logic [31:0]                 prdata;
  logic                        pready;

  i2c_eeprom_byte_master_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),  // [7:0] word_addr, [15:8] write_data, [16] sda_in
    .s_tuser  (s_tuser),  // [1:0] action
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),  // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res,
                          // [4] ack_ok, [12:5] read_data
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // bus master mirror
  logic [7:0] dev_byte;
  bus_phase_t phase;
  logic [1:0] qtr;
  logic [3:0] nbits;
  logic [7:0] shreg;
  logic [7:0] wa_q;
  logic [7:0] wd_q;
  logic       rd_op;
  logic [7:0] rx_byte;
  logic       ack_good;
  logic       scl_q;
  logic       sda_q;

  i2cebm_pkg::res_t bus_words_q[$];
  i2cebm_pkg::res_t want_w;
  i2cebm_pkg::res_t got_w;
  int               errors;
  int               items_sent;
  int               rx_hold;
  bit               quiet;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic reset_mirror();
    dev_byte = i2cebm_pkg::DEV_RESET;
    phase    = BP_IDLE;
    qtr      = 2'd0;
    nbits    = 4'd0;
    shreg    = 8'd0;
    wa_q     = 8'd0;
    wd_q     = 8'd0;
    rd_op    = 1'b0;
    rx_byte  = 8'd0;
    ack_good = 1'b1;
    scl_q    = 1'b1;
    sda_q    = 1'b1;
  endtask

  task automatic load_byte(input bus_phase_t ph, input logic [7:0] v);
    phase = ph;
    shreg = v;
    nbits = 4'd0;
  endtask

  // advance the mirror by one accepted word and queue the bus word it yields
  task automatic predict_bus(input logic [1:0] act, input logic [7:0] wa, input logic [7:0] wd,
                             input logic sdi);
    logic [1:0]       q;
    logic             fin;
    i2cebm_pkg::res_t r;
    fin = 1'b0;
    q   = qtr;
    if (act == i2cebm_pkg::ACT_TICK) begin
      if (phase != BP_IDLE) begin
        qtr = q + 2'd1;
        case (phase)
          BP_START, BP_RSTART: begin
            case (q)
              2'd0: sda_q = 1'b1;
              2'd1: scl_q = 1'b1;
              2'd2: sda_q = 1'b0;
              default: begin
                scl_q = 1'b0;
                if (phase == BP_START) load_byte(BP_DEVW, dev_byte);
                else load_byte(BP_DEVR, dev_byte + 8'd1);
              end
            endcase
          end
          BP_DEVW, BP_WA, BP_DATA, BP_DEVR: begin
            case (q)
              2'd0: begin
                scl_q = 1'b0;
                sda_q = shreg[7];
              end
              2'd1: scl_q = 1'b1;
              2'd3: begin
                scl_q = 1'b0;
                shreg = shreg << 1;
                nbits = nbits + 4'd1;
                if (nbits >= 4'd8) begin
                  nbits = 4'd0;
                  phase = bus_phase_t'(phase + 1);
                end
              end
              default: ;
            endcase
          end
          BP_DEVW_A, BP_WA_A, BP_DATA_A, BP_DEVR_A: begin
            case (q)
              2'd0: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
              end
              2'd1: scl_q = 1'b1;
              2'd2: if (sdi) ack_good = 1'b0;
              default: begin
                scl_q = 1'b0;
                if (!ack_good) phase = BP_STOP;
                else if (phase == BP_DEVW_A) load_byte(BP_WA, wa_q);
                else if (phase == BP_WA_A) begin
                  if (rd_op) phase = BP_RSTART;
                  else load_byte(BP_DATA, wd_q);
                end else if (phase == BP_DATA_A) phase = BP_STOP;
                else begin
                  phase = BP_READ;
                  nbits = 4'd0;
                end
              end
            endcase
          end
          BP_READ: begin
            case (q)
              2'd0: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
              end
              2'd1: scl_q = 1'b1;
              2'd2: rx_byte = {rx_byte[6:0], sdi};
              default: begin
                scl_q = 1'b0;
                nbits = nbits + 4'd1;
                if (nbits >= 4'd8) begin
                  nbits = 4'd0;
                  phase = BP_NACK;
                end
              end
            endcase
          end
          BP_NACK: begin
            case (q)
              2'd0: begin
                scl_q = 1'b0;
                sda_q = 1'b1;
              end
              2'd1: scl_q = 1'b1;
              2'd3: begin
                scl_q = 1'b0;
                phase = BP_STOP;
              end
              default: ;
            endcase
          end
          BP_STOP: begin
            case (q)
              2'd0: begin
                scl_q = 1'b0;
                sda_q = 1'b0;
              end
              2'd1: scl_q = 1'b1;
              2'd2: sda_q = 1'b1;
              default: begin
                scl_q = 1'b1;
                sda_q = 1'b1;
                phase = BP_IDLE;
                fin   = 1'b1;
              end
            endcase
          end
          default: begin
            phase = BP_IDLE;
            qtr   = 2'd0;
            nbits = 4'd0;
            scl_q = 1'b1;
            sda_q = 1'b1;
          end
        endcase
      end
    end else if ((act == i2cebm_pkg::ACT_WRITE || act == i2cebm_pkg::ACT_READ)
                 && phase == BP_IDLE) begin
      wa_q     = wa;
      wd_q     = wd;
      rd_op    = (act == i2cebm_pkg::ACT_READ);
      rx_byte  = 8'd0;
      ack_good = 1'b1;
      nbits    = 4'd0;
      qtr      = 2'd0;
      shreg    = 8'd0;
      phase    = BP_START;
    end
    r           = '0;
    r.scl       = scl_q;
    r.sda       = sda_q;
    r.busy      = (phase != BP_IDLE);
    r.done      = fin;
    r.ack_ok    = fin && ack_good;
    r.read_data = (fin && ack_good && rd_op) ? rx_byte : 8'd0;
    bus_words_q.push_back(r);
  endtask

  // slave-side data level for the next tick
  function automatic logic pick_sda(input int fail_pct, input bus_phase_t nack_at,
                                    input int rd_mode);
    if ((phase == BP_DEVW_A || phase == BP_WA_A || phase == BP_DATA_A || phase == BP_DEVR_A)
        && qtr == 2'd2)
      return (phase == nack_at) || ($urandom_range(99) < fail_pct);
    if (phase == BP_READ && qtr == 2'd2 && rd_mode == 0) return 1'b0;
    if (phase == BP_READ && qtr == 2'd2 && rd_mode == 1) return 1'b1;
    return 1'($urandom_range(1));
  endfunction

  task automatic send_word(input logic [1:0] act, input logic [7:0] wa, input logic [7:0] wd,
                           input logic sdi);
    while (!quiet && $urandom_range(99) < 9) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {7'd0, sdi, wd, wa};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_bus(act, wa, wd, sdi);
    items_sent++;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (bus_words_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_dev(input logic [7:0] v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DEV;
    pwdata  <= {24'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    dev_byte = v;
  endtask

  // one transaction from begin to idle, with optional junk words mixed in
  task automatic run_txn(input logic [1:0] op, input logic [7:0] wa, input logic [7:0] wd,
                         input int fail_pct, input int noise_pct, input int rd_mode,
                         input bus_phase_t nack_at);
    send_word(op, wa, wd, 1'($urandom_range(1)));
    while (phase != BP_IDLE) begin
      if ($urandom_range(99) < noise_pct)
        send_word(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                  1'($urandom_range(1)));
      else
        send_word(i2cebm_pkg::ACT_TICK, 8'($urandom), 8'($urandom),
                  pick_sda(fail_pct, nack_at, rd_mode));
    end
  endtask

  function automatic bus_phase_t any_ack();
    case ($urandom_range(3))
      0: return BP_DEVW_A;
      1: return BP_WA_A;
      2: return BP_DATA_A;
      default: return BP_DEVR_A;
    endcase
  endfunction

  task automatic test_idle_steps();
    send_word(i2cebm_pkg::ACT_TICK, 8'h00, 8'h00, 1'b0);
    send_word(i2cebm_pkg::ACT_TICK, 8'hFF, 8'hFF, 1'b1);
    send_word(ACT_NOP, 8'hFF, 8'hFF, 1'b1);
    send_word(ACT_NOP, 8'h00, 8'h00, 1'b0);
  endtask

  task automatic test_clean_write();
    run_txn(i2cebm_pkg::ACT_WRITE, 8'hFF, 8'h00, 0, 0, 2, BP_IDLE);
    run_txn(i2cebm_pkg::ACT_WRITE, 8'h00, 8'hFF, 0, 0, 2, BP_IDLE);
  endtask

  task automatic test_clean_read();
    run_txn(i2cebm_pkg::ACT_READ, 8'h5A, 8'h00, 0, 0, 0, BP_IDLE);
    run_txn(i2cebm_pkg::ACT_READ, 8'hA5, 8'hFF, 0, 0, 1, BP_IDLE);
  endtask

  task automatic test_missing_ack();
    run_txn(i2cebm_pkg::ACT_WRITE, 8'h55, 8'h66, 0, 0, 2, BP_DATA_A);
    run_txn(i2cebm_pkg::ACT_READ, 8'h77, 8'h88, 0, 0, 1, BP_DEVW_A);
    run_txn(i2cebm_pkg::ACT_READ, 8'h99, 8'hAA, 0, 0, 1, BP_WA_A);
    run_txn(i2cebm_pkg::ACT_READ, 8'hBB, 8'hCC, 0, 0, 1, BP_DEVR_A);
  endtask

  // begins while busy and action 3 must leave the bus untouched
  task automatic test_busy_junk();
    run_txn(i2cebm_pkg::ACT_READ, 8'($urandom), 8'($urandom), 0, 30, 2, BP_IDLE);
  endtask

  task automatic test_device_bytes();
    logic [7:0] vals [2];
    vals = '{8'h00, 8'hFF};
    foreach (vals[i]) begin
      write_dev(vals[i]);
      run_txn(i2cebm_pkg::ACT_READ, 8'($urandom), 8'($urandom), 0, 0, 2, BP_IDLE);
    end
  endtask

  // receiver stalls long enough for the input side to back up
  task automatic test_backpressure();
    drain();
    rx_hold = 300;
    run_txn(i2cebm_pkg::ACT_WRITE, 8'($urandom), 8'($urandom), 0, 0, 2, BP_IDLE);
    drain();
  endtask

  task automatic test_random(input int n);
    int seg_end;
    for (int k = 0; k < 4; k++) begin
      write_dev(8'($urandom));
      quiet   = (k == 2);
      seg_end = items_sent + n / 4;
      while (items_sent < seg_end) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(1, 4))
            send_word($urandom_range(1) ? i2cebm_pkg::ACT_TICK : ACT_NOP,
                      8'($urandom), 8'($urandom), 1'($urandom_range(1)));
        end
        run_txn($urandom_range(1) ? i2cebm_pkg::ACT_READ : i2cebm_pkg::ACT_WRITE,
                8'($urandom), 8'($urandom),
                2, 4, 2, ($urandom_range(9) == 0) ? any_ack() : BP_IDLE);
      end
      quiet = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rx_hold > 0) begin
      m_tready <= 1'b0;
      rx_hold--;
    end else begin
      m_tready <= quiet || ($urandom_range(99) >= 9);
    end
  end

  task automatic cmp_field(input string nm, input logic [7:0] e, input logic [7:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %h got %h", $time, nm, e, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (bus_words_q.size() == 0) begin
        $display("%0t: word with nothing expected, got %h", $time, m_tdata);
        errors++;
      end else begin
        want_w = bus_words_q.pop_front();
        got_w  = i2cebm_pkg::res_t'(m_tdata);
        cmp_field("scl_out", 8'(want_w.scl), 8'(got_w.scl));
        cmp_field("sda_out", 8'(want_w.sda), 8'(got_w.sda));
        cmp_field("busy_res", 8'(want_w.busy), 8'(got_w.busy));
        cmp_field("done_res", 8'(want_w.done), 8'(got_w.done));
        cmp_field("ack_ok", 8'(want_w.ack_ok), 8'(got_w.ack_ok));
        cmp_field("read_data", want_w.read_data, got_w.read_data);
      end
    end
  end

  initial begin
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = i2cebm_pkg::ACT_TICK;
    m_tready   = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = REG_DEV;
    pwdata     = '0;
    errors     = 0;
    items_sent = 0;
    rx_hold    = 0;
    quiet      = 1'b0;
    reset_mirror();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_steps();
    test_clean_write();
    test_clean_read();
    test_missing_ack();
    test_busy_junk();
    test_device_bytes();
    test_backpressure();
    test_random(400);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/i2cebm_pkg.sv
src/i2cebm_front.sv
src/i2cebm_queue.sv
src/i2cebm_back.sv
src/i2c_eeprom_byte_master_core.sv
src/i2cebm_checker.sv
bench/i2c_eeprom_byte_master_core_tb.sv
